// ===== hdl/mixed_radix_index_converter_unit_macros.svh =====
// Assertion macros for the index converter.
`ifndef MIXED_RADIX_INDEX_CONVERTER_UNIT_MACROS_SVH
`define MIXED_RADIX_INDEX_CONVERTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define MRIC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mric assertion failed");
// Next-cycle implication.
`define MRIC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mric assertion failed");
`else
`define MRIC_ASSERT_NOW(label, ante, cons)
`define MRIC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== hdl/mric_pkg.sv =====
package mric_pkg;

  localparam int MaxDims  = 4;
  localparam int IdxW     = 10;
  localparam int FlatW    = 40;
  localparam int SizeW    = 11;
  localparam int NumDimsW = 3;
  localparam int CfgIdxW  = 3;
  localparam int HalfW    = FlatW / 2;
  localparam int ProdW    = HalfW + SizeW;

  localparam logic [FlatW-1:0] FlatMax = {FlatW{1'b1}};
  localparam logic [FlatW-1:0] IdxMax  = FlatW'({IdxW{1'b1}});

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgNumDims = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSize0   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSize1   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSize2   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgSize3   = 3'd4;

  // Operation codes.
  localparam logic OpFlatten = 1'b0;
  localparam logic OpSplit   = 1'b1;

  // Effective configuration seen by every cell.
  typedef struct packed {
    logic [NumDimsW-1:0]            n;
    logic [MaxDims-1:0][SizeW-1:0]  s;
  } cfg_t;

  // Item state handed from cell to cell.
  typedef struct packed {
    logic                          op;
    logic                          flag;
    logic [MaxDims-1:0][IdxW-1:0]  idx;
    logic [FlatW-1:0]              work;
    logic [SizeW-1:0]              rem;
    logic [ProdW-1:0]              plo;
    logic [ProdW-1:0]              phi;
  } pl_t;

  // Clamp a value to the largest index.
  function automatic logic [IdxW-1:0] sat_idx(input logic [FlatW-1:0] v);
    return (v > IdxMax) ? IdxMax[IdxW-1:0] : v[IdxW-1:0];
  endfunction

endpackage

// ===== hdl/mixed_radix_index_converter_unit.sv =====
// Channel   Dir  tdata (low bit first)                          tuser
// s_axis    in   in_idx0, in_idx1, in_idx2, in_idx3, in_flat     opcode
// m_axis    out  out_flat, out_idx0, out_idx1, out_idx2, out_idx3 out_of_range
// cfg       in   write enable, register index, 11-bit data       -
//
// One transfer is accepted per cycle while no stall backs up to the input, so new items
// enter before earlier ones leave. The chain: an entry stage, six multiply/add cells for the
// flatten, 120 one-bit divider cells (40 per division) and the output register.
// Every stage advances when it is empty or the stage after it advances, so bubbles
// fill up behind a stalled output. Reset clears all valid bits and the
// configuration (one dimension, all sizes one).
`include "mixed_radix_index_converter_unit_macros.svh"

module mixed_radix_index_converter_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mric_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mric_pkg::SizeW-1:0]    cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [79:0]                   s_axis_tdata,  // in_idx0..in_idx3, in_flat
  input  logic                          s_axis_tuser,  // opcode
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [79:0]                   m_axis_tdata,  // out_flat, out_idx0..out_idx3
  output logic                          m_axis_tuser   // out_of_range
);
  import mric_pkg::*;

  localparam int HornerStages = 2 * (MaxDims - 1);
  localparam int DivStages    = (MaxDims - 1) * FlatW;
  localparam int NumStages    = HornerStages + DivStages + 2;
  localparam int DivBase      = 1 + HornerStages;
  localparam int OutStage     = NumStages - 1;

  logic [NumDimsW-1:0]           num_dims_q;
  logic [MaxDims-1:0][SizeW-1:0] size_q;
  cfg_t                          cfg;

  pl_t                  pl [NumStages];
  logic [NumStages-1:0] vld_q;
  logic [NumStages:0]   adv;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_dims_q <= NumDimsW'(1);
      size_q     <= {MaxDims{SizeW'(1)}};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgNumDims: num_dims_q <= cfg_data_i[NumDimsW-1:0];
        CfgSize0:   size_q[0]  <= cfg_data_i;
        CfgSize1:   size_q[1]  <= cfg_data_i;
        CfgSize2:   size_q[2]  <= cfg_data_i;
        CfgSize3:   size_q[3]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective dimension count and sizes: zero means one, the count tops out at four.
  always_comb begin
    if (num_dims_q == '0) begin
      cfg.n = NumDimsW'(1);
    end else if (num_dims_q > NumDimsW'(MaxDims)) begin
      cfg.n = NumDimsW'(MaxDims);
    end else begin
      cfg.n = num_dims_q;
    end
    for (int d = 0; d < MaxDims; d++) begin
      cfg.s[d] = (size_q[d] == '0) ? SizeW'(1) : size_q[d];
    end
  end

  // Stage advance chain, from the output back to the input.
  assign adv[NumStages] = m_axis_tready;
  for (genvar k = 0; k < NumStages; k++) begin : g_adv
    assign adv[k] = !vld_q[k] || adv[k+1];
  end
  assign s_axis_tready = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Entry stage: range check and the start value of the accumulator or dividend.
  pl_t entry_d, entry_q;
  always_comb begin
    logic [NumDimsW-1:0] top;
    entry_d      = '0;
    entry_d.op   = s_axis_tuser;
    for (int d = 0; d < MaxDims; d++) begin
      entry_d.idx[d] = s_axis_tdata[d*IdxW +: IdxW];
    end
    top = cfg.n - NumDimsW'(1);
    if (s_axis_tuser == OpSplit) begin
      entry_d.work = s_axis_tdata[MaxDims*IdxW +: FlatW];
    end else begin
      entry_d.work = FlatW'(entry_d.idx[top[1:0]]);
      for (int d = 0; d < MaxDims; d++) begin
        if ((NumDimsW'(d) < cfg.n) && (SizeW'(entry_d.idx[d]) >= cfg.s[d])) begin
          entry_d.flag = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      entry_q <= entry_d;
    end
  end
  assign pl[0] = entry_q;

  // Horner cells, slowest dimension first.
  for (genvar j = 0; j < MaxDims - 1; j++) begin : g_horner
    localparam int Dim = MaxDims - 1 - j;
    mric_mul_cell #(.DIM(Dim)) u_mul (
      .clk_i (clk_i),
      .en_i  (adv[1 + 2*j]),
      .cfg_i (cfg),
      .pl_i  (pl[2*j]),
      .pl_o  (pl[1 + 2*j])
    );
    mric_add_cell #(.DIM(Dim)) u_add (
      .clk_i (clk_i),
      .en_i  (adv[2 + 2*j]),
      .cfg_i (cfg),
      .pl_i  (pl[1 + 2*j]),
      .pl_o  (pl[2 + 2*j])
    );
  end

  // Divider cells, one quotient bit each, fastest dimension first.
  for (genvar d = 0; d < MaxDims - 1; d++) begin : g_div
    for (genvar b = 0; b < FlatW; b++) begin : g_bit
      localparam int Stage = DivBase + d*FlatW + b;
      mric_div_cell #(
        .DIM   (d),
        .FIRST (b == 0),
        .LAST  (b == FlatW - 1)
      ) u_div (
        .clk_i (clk_i),
        .en_i  (adv[Stage]),
        .cfg_i (cfg),
        .pl_i  (pl[Stage-1]),
        .pl_o  (pl[Stage])
      );
    end
  end

  // Output stage: last split index from the remaining quotient, unused fields cleared.
  pl_t out_d, out_q;
  always_comb begin
    pl_t src;
    src          = pl[OutStage-1];
    out_d        = src;
    out_d.work   = (src.op == OpSplit) ? '0 : src.work;
    for (int d = 0; d < MaxDims; d++) begin
      if ((src.op == OpSplit) && (NumDimsW'(d) < cfg.n)) begin
        if ((NumDimsW'(d + 1) == cfg.n) && (cfg.n != NumDimsW'(1))) begin
          out_d.idx[d] = sat_idx(src.work);
        end else begin
          out_d.idx[d] = src.idx[d];
        end
      end else begin
        out_d.idx[d] = '0;
      end
    end
    if ((src.op == OpSplit) && (cfg.n != NumDimsW'(1)) && (src.work > IdxMax)) begin
      out_d.flag = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[OutStage]) begin
      out_q <= out_d;
    end
  end
  assign pl[OutStage] = out_q;

  assign m_axis_tvalid = vld_q[OutStage];
  assign m_axis_tdata  = {out_q.idx[3], out_q.idx[2], out_q.idx[1], out_q.idx[0], out_q.work};
  assign m_axis_tuser  = out_q.flag;

  // An empty output stage lets the whole chain move, so the input must be ready.
  `MRIC_ASSERT_NOW(a_ready_when_out_empty, !m_axis_tvalid, s_axis_tready)
  // A split result never carries a flat index.
  `MRIC_ASSERT_NOW(a_split_no_flat, m_axis_tvalid && out_q.op == OpSplit,
                   m_axis_tdata[FlatW-1:0] == '0)
  // With one dimension only the first index can be nonzero.
  `MRIC_ASSERT_NOW(a_one_dim_upper_zero, m_axis_tvalid && cfg.n == NumDimsW'(1),
                   m_axis_tdata[79:50] == '0)
  // A stalled output keeps its item.
  `MRIC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

endmodule

// ===== hdl/mric_mul_cell.sv =====
module mric_mul_cell #(
  parameter int DIM = 1
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  mric_pkg::cfg_t cfg_i,
  input  mric_pkg::pl_t  pl_i,
  output mric_pkg::pl_t  pl_o
);
  import mric_pkg::*;

  pl_t pl_d, pl_q;

  // Both halves of the accumulator times the size of the next faster dimension.
  always_comb begin
    pl_d     = pl_i;
    pl_d.plo = ProdW'(pl_i.work[HalfW-1:0]) * ProdW'(cfg_i.s[DIM-1]);
    pl_d.phi = ProdW'(pl_i.work[FlatW-1:HalfW]) * ProdW'(cfg_i.s[DIM-1]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q <= pl_d;
    end
  end

  assign pl_o = pl_q;
endmodule

// ===== hdl/mric_add_cell.sv =====
module mric_add_cell #(
  parameter int DIM = 1
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  mric_pkg::cfg_t cfg_i,
  input  mric_pkg::pl_t  pl_i,
  output mric_pkg::pl_t  pl_o
);
  import mric_pkg::*;

  localparam int SumW = FlatW + SizeW + 1;

  pl_t pl_d, pl_q;

  // Join the partial products, add the next index and saturate.
  always_comb begin
    logic [SumW-1:0] sum;
    logic            active;
    pl_d   = pl_i;
    active = (pl_i.op == OpFlatten) && (NumDimsW'(DIM) < cfg_i.n);
    sum    = SumW'({pl_i.phi, {HalfW{1'b0}}}) + SumW'(pl_i.plo) + SumW'(pl_i.idx[DIM-1]);
    if (active) begin
      if (sum > SumW'(FlatMax)) begin
        pl_d.work = FlatMax;
        pl_d.flag = 1'b1;
      end else begin
        pl_d.work = sum[FlatW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q <= pl_d;
    end
  end

  assign pl_o = pl_q;
endmodule

// ===== hdl/mric_div_cell.sv =====
module mric_div_cell #(
  parameter int DIM   = 0,
  parameter bit FIRST = 1'b0,
  parameter bit LAST  = 1'b0
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  mric_pkg::cfg_t cfg_i,
  input  mric_pkg::pl_t  pl_i,
  output mric_pkg::pl_t  pl_o
);
  import mric_pkg::*;

  pl_t pl_d, pl_q;

  // One restoring division step: quotient bits shift in where dividend bits leave.
  always_comb begin
    logic               active;
    logic [SizeW-1:0]   rin;
    logic [SizeW:0]     t;
    logic               ge;
    logic [SizeW:0]     rnew;
    pl_d   = pl_i;
    active = (pl_i.op == OpSplit) &&
             ((NumDimsW'(DIM + 1) < cfg_i.n) || ((DIM == 0) && (cfg_i.n == NumDimsW'(1))));
    rin    = FIRST ? '0 : pl_i.rem;
    t      = {rin, pl_i.work[FlatW-1]};
    ge     = (t >= {1'b0, cfg_i.s[DIM]});
    rnew   = ge ? (t - {1'b0, cfg_i.s[DIM]}) : t;
    if (active) begin
      pl_d.work = {pl_i.work[FlatW-2:0], ge};
      pl_d.rem  = rnew[SizeW-1:0];
      if (LAST) begin
        pl_d.idx[DIM] = sat_idx(FlatW'(rnew));
        if (FlatW'(rnew) > IdxMax) begin
          pl_d.flag = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q <= pl_d;
    end
  end

  assign pl_o = pl_q;
endmodule
